FILE: design/pcc_pkg.sv
// shared constants, types and helper functions for the packed channel concatenator
// no dependencies; every other design file but pcc_ram refers to this package by scoped names
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int LANES   = 8;
  localparam int MAX_CH  = 64;
  localparam int LANE_W  = 8;
  localparam int DATA_W  = LANES * LANE_W;

  // widths fixed by the register map and the counters
  localparam int CFG_CH_W  = 7;
  localparam int DIM_W     = 11;
  localparam int CNT_W     = 10;
  localparam int WC_W      = 4;
  localparam int MAX_DIM   = 1024;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = DIM_W;

  // derived sizes
  localparam int CH_W   = $clog2(MAX_CH + 1);
  localparam int DST_W  = CH_W + 1;
  localparam int ROWS   = (MAX_CH + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LIDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int BANK_DEPTH = 2 * ROWS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CH_FIRST  = 2'd0,
    REG_CH_SECOND = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_WIDTH     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_CH_W-1:0] ch_first;
    logic [CFG_CH_W-1:0] ch_second;
    logic [DIM_W-1:0]    height;
    logic [DIM_W-1:0]    width;
  } cfg_t;

  // write request into the lane banks for one accepted word
  typedef struct packed {
    logic            valid;
    logic            sel;
    logic [CH_W-1:0] base;
    logic [WC_W-1:0] word_idx;
    logic [CH_W-1:0] limit;
  } lane_wr_t;

  // row read from the lane banks
  typedef struct packed {
    logic             en;
    logic             sel;
    logic [ROW_W-1:0] row;
  } lane_rd_t;

  // completed pixel waiting for read-out
  typedef struct packed {
    logic            ready;
    logic            sel;
    logic [CH_W-1:0] total;
    logic            frame_end;
  } pix_stat_t;

  function automatic logic [CH_W-1:0] eff_channels(input logic [CFG_CH_W-1:0] v);
    logic [CH_W-1:0] r;
    if (v == '0) begin
      r = CH_W'(1);
    end else if (CH_W'(v) > CH_W'(MAX_CH)) begin
      r = CH_W'(MAX_CH);
    end else begin
      r = CH_W'(v);
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [WC_W-1:0] words_for(input logic [CH_W-1:0] ch);
    logic [DST_W-1:0] s;
    s = DST_W'(ch) + DST_W'(LANES - 1);
    return WC_W'(s / LANES);
  endfunction

endpackage

FILE: design/pcc_if.sv
// request channels of the packed channel concatenator: packed input words and repacked output
// depends on pcc_pkg for the data width
`timescale 1ns / 1ps

interface pcc_in_if;
  logic                      valid;
  logic                      ready;
  logic [pcc_pkg::DATA_W-1:0] pack_data;

  modport source (output valid, output pack_data, input ready);
  modport sink   (input valid, input pack_data, output ready);
endinterface

interface pcc_out_if;
  logic                      valid;
  logic                      ready;
  logic [pcc_pkg::DATA_W-1:0] out_data;
  logic                      pixel_last;
  logic                      frame_last;

  modport source (output valid, output out_data, output pixel_last, output frame_last,
                  input ready);
  modport sink   (input valid, input out_data, input pixel_last, input frame_last,
                  output ready);
endinterface

FILE: design/packed_channel_concatenator.sv
// Takes one packed input word per cycle. Each pixel arrives as ceil(channels_first/8)
// words of the first stream followed by ceil(channels_second/8) words of the second; the
// valid lanes are steered into eight lane banks that hold two pixels, so the next pixel fills
// one half while the other half is read out. After its last word, a pixel's repacked words
// (ceil(min(first+second, 64)/8) of them) pass the full flag, bank read and output registers,
// one per cycle while the sink takes them. Input stalls only when a second pixel completes
// before the previous one is fully read out of the banks; since a pixel never yields more
// output words than it took input words, with a free-running sink the input is never held.
// Depends on pcc_pkg, pcc_if, pcc_ctrl, pcc_lane, pcc_ram and pcc_merge.
`timescale 1ns / 1ps

module packed_channel_concatenator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcc_pkg::CFG_W-1:0]     cfg_data,
  pcc_in_if.sink                        data_in,
  pcc_out_if.source                     data_out
);

  pcc_pkg::cfg_t              cfg;
  pcc_pkg::lane_wr_t          wr;
  pcc_pkg::lane_rd_t          rd;
  pcc_pkg::pix_stat_t         stat;
  logic [pcc_pkg::DATA_W-1:0] wr_data;
  logic [pcc_pkg::DATA_W-1:0] bank_data;
  logic                       buf_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ch_first  <= pcc_pkg::CFG_CH_W'(1);
      cfg.ch_second <= pcc_pkg::CFG_CH_W'(1);
      cfg.height    <= pcc_pkg::DIM_W'(1);
      cfg.width     <= pcc_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      unique case (pcc_pkg::cfg_reg_t'(cfg_index))
        pcc_pkg::REG_CH_FIRST:  cfg.ch_first  <= cfg_data[pcc_pkg::CFG_CH_W-1:0];
        pcc_pkg::REG_CH_SECOND: cfg.ch_second <= cfg_data[pcc_pkg::CFG_CH_W-1:0];
        pcc_pkg::REG_HEIGHT:    cfg.height    <= cfg_data[pcc_pkg::DIM_W-1:0];
        pcc_pkg::REG_WIDTH:     cfg.width     <= cfg_data[pcc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  pcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .data_in  (data_in),
    .wr       (wr),
    .wr_data  (wr_data),
    .stat     (stat),
    .buf_done (buf_done)
  );

  for (genvar g = 0; g < pcc_pkg::LANES; g++) begin : g_lane
    pcc_lane u_lane (
      .clk      (clk),
      .lane_idx (pcc_pkg::LIDX_W'(g)),
      .wr       (wr),
      .wr_data  (wr_data),
      .rd       (rd),
      .rdata    (bank_data[g*pcc_pkg::LANE_W +: pcc_pkg::LANE_W])
    );
  end

  pcc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .bank_data (bank_data),
    .rd        (rd),
    .buf_done  (buf_done),
    .data_out  (data_out)
  );

endmodule

FILE: design/pcc_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pcc_lane.sv
// one lane bank: steers its byte of the input word into a two-pixel store, reads rows back
// depends on pcc_pkg and pcc_ram
`timescale 1ns / 1ps

module pcc_lane (
  input  logic                               clk,
  input  logic [pcc_pkg::LIDX_W-1:0]         lane_idx,
  input  pcc_pkg::lane_wr_t                  wr,
  input  logic [pcc_pkg::DATA_W-1:0]         wr_data,
  input  pcc_pkg::lane_rd_t                  rd,
  output logic [pcc_pkg::LANE_W-1:0]         rdata
);

  logic [pcc_pkg::LIDX_W-1:0] rot;
  logic [pcc_pkg::DST_W-1:0]  ch;
  logic [pcc_pkg::DST_W-1:0]  dst;
  logic [pcc_pkg::ROW_W-1:0]  row;
  logic                       we;
  logic [pcc_pkg::LANE_W-1:0] lane_byte;

  // channel dst lands in bank dst % LANES, so this bank takes input lane (idx - base) mod LANES
  always_comb begin
    rot = pcc_pkg::LIDX_W'((pcc_pkg::DST_W'(lane_idx) + pcc_pkg::DST_W'(pcc_pkg::LANES)
          - pcc_pkg::DST_W'(wr.base) % pcc_pkg::LANES) % pcc_pkg::LANES);
    ch  = pcc_pkg::DST_W'(wr.word_idx) * pcc_pkg::DST_W'(pcc_pkg::LANES)
          + pcc_pkg::DST_W'(rot);
    dst = ch + pcc_pkg::DST_W'(wr.base);
    row = pcc_pkg::ROW_W'(dst / pcc_pkg::LANES);
    we  = wr.valid && (ch < pcc_pkg::DST_W'(wr.limit))
          && (dst < pcc_pkg::DST_W'(pcc_pkg::MAX_CH));
    lane_byte = wr_data[rot*pcc_pkg::LANE_W +: pcc_pkg::LANE_W];
  end

  pcc_ram #(
    .WIDTH (pcc_pkg::LANE_W),
    .DEPTH (pcc_pkg::BANK_DEPTH)
  ) u_bank (
    .clk   (clk),
    .we    (we),
    .waddr ({wr.sel, row}),
    .wdata (lane_byte),
    .re    (rd.en),
    .raddr ({rd.sel, rd.row}),
    .rdata (rdata)
  );

endmodule

FILE: design/pcc_ctrl.sv
// input sequencer: word, stream, column and row counters, and the two pixel buffer flags
// depends on pcc_pkg and pcc_if
`timescale 1ns / 1ps

module pcc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  pcc_pkg::cfg_t              cfg,
  pcc_in_if.sink                     data_in,
  output pcc_pkg::lane_wr_t          wr,
  output logic [pcc_pkg::DATA_W-1:0] wr_data,
  output pcc_pkg::pix_stat_t         stat,
  input  logic                       buf_done
);

  logic [pcc_pkg::WC_W-1:0]  word_count;
  logic                      second_phase;
  logic [pcc_pkg::CNT_W-1:0] column_count;
  logic [pcc_pkg::CNT_W-1:0] row_count;
  logic                      wr_sel;
  logic                      rd_sel;
  logic [1:0]                full;
  logic [pcc_pkg::CH_W-1:0]  total_buf [2];
  logic [1:0]                frame_end_buf;

  logic [pcc_pkg::CH_W-1:0]  ca, cb, limit, base, total;
  logic [pcc_pkg::DST_W-1:0] sum;
  logic [pcc_pkg::WC_W-1:0]  wc_inc;
  logic                      more;
  logic                      accept;
  logic                      pix_done;
  logic [pcc_pkg::DIM_W-1:0] col_inc, row_inc;
  logic                      col_wrap, row_wrap;
  logic [1:0]                full_next;

  always_comb begin
    ca     = pcc_pkg::eff_channels(cfg.ch_first);
    cb     = pcc_pkg::eff_channels(cfg.ch_second);
    limit  = second_phase ? cb : ca;
    base   = second_phase ? ca : '0;
    sum    = pcc_pkg::DST_W'(ca) + pcc_pkg::DST_W'(cb);
    total  = (sum > pcc_pkg::DST_W'(pcc_pkg::MAX_CH)) ? pcc_pkg::CH_W'(pcc_pkg::MAX_CH)
                                                     : pcc_pkg::CH_W'(sum);
    wc_inc = word_count + pcc_pkg::WC_W'(1);
    more   = (wc_inc != '0) && (wc_inc < pcc_pkg::words_for(limit));
    accept = data_in.valid && data_in.ready;
    pix_done = accept && !more && second_phase;
    col_inc  = pcc_pkg::DIM_W'(column_count) + pcc_pkg::DIM_W'(1);
    row_inc  = pcc_pkg::DIM_W'(row_count) + pcc_pkg::DIM_W'(1);
    col_wrap = col_inc >= pcc_pkg::eff_dim(cfg.width);
    row_wrap = row_inc >= pcc_pkg::eff_dim(cfg.height);
    // a pixel finishing and a buffer being released always touch different halves
    full_next = full;
    if (pix_done) begin
      full_next[wr_sel] = 1'b1;
    end
    if (buf_done) begin
      full_next[rd_sel] = 1'b0;
    end
  end

  assign data_in.ready = !full[wr_sel];

  assign wr.valid    = accept;
  assign wr.sel      = wr_sel;
  assign wr.base     = base;
  assign wr.word_idx = word_count;
  assign wr.limit    = limit;
  assign wr_data     = data_in.pack_data;

  assign stat.ready     = full[rd_sel];
  assign stat.sel       = rd_sel;
  assign stat.total     = total_buf[rd_sel];
  assign stat.frame_end = frame_end_buf[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count   <= '0;
      second_phase <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
      wr_sel       <= 1'b0;
      rd_sel       <= 1'b0;
      full         <= '0;
    end else begin
      full <= full_next;
      if (accept) begin
        if (more) begin
          word_count <= wc_inc;
        end else begin
          word_count   <= '0;
          second_phase <= !second_phase;
        end
      end
      if (pix_done) begin
        if (col_wrap) begin
          column_count <= '0;
          if (row_wrap) begin
            row_count <= '0;
          end else begin
            row_count <= pcc_pkg::CNT_W'(row_inc);
          end
        end else begin
          column_count <= pcc_pkg::CNT_W'(col_inc);
        end
        wr_sel <= !wr_sel;
      end
      // read side frees its buffer once the last row read is issued
      if (buf_done) begin
        rd_sel <= !rd_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_done) begin
      total_buf[wr_sel]     <= total;
      frame_end_buf[wr_sel] <= col_wrap && row_wrap;
    end
  end

  a_done_from_full: assert property (@(posedge clk) disable iff (rst)
    buf_done |-> full[rd_sel])
    else $error("buffer released while not holding a pixel");

  a_both_full: assert property (@(posedge clk) disable iff (rst)
    (full[0] && full[1]) |-> (wr_sel == rd_sel))
    else $error("buffer pointers disagree with both buffers full");

  a_both_empty: assert property (@(posedge clk) disable iff (rst)
    (!full[0] && !full[1]) |-> (wr_sel == rd_sel))
    else $error("buffer pointers disagree with both buffers empty");

endmodule

FILE: design/pcc_merge.sv
// read-out and merge stage: walks the rows of a finished pixel, masks unused lanes,
// adds pixel and frame marks; depends on pcc_pkg and pcc_if
`timescale 1ns / 1ps

module pcc_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  pcc_pkg::pix_stat_t         stat,
  input  logic [pcc_pkg::DATA_W-1:0] bank_data,
  output pcc_pkg::lane_rd_t          rd,
  output logic                       buf_done,
  pcc_out_if.source                  data_out
);

  logic [pcc_pkg::ROW_W-1:0]  row_cnt;
  logic                       s1_valid;
  logic [pcc_pkg::ROW_W-1:0]  s1_row;
  logic [pcc_pkg::CH_W-1:0]   s1_total;
  logic                       s1_fe;
  logic                       s1_last;
  logic                       out_valid;
  logic [pcc_pkg::DATA_W-1:0] out_data;
  logic                       out_pl;
  logic                       out_fl;

  logic                       out_take, s1_move, s1_free, issue, last;
  logic [pcc_pkg::DATA_W-1:0] masked;
  logic [pcc_pkg::DST_W-1:0]  ch;

  always_comb begin
    out_take = !out_valid || data_out.ready;
    s1_move  = s1_valid && out_take;
    s1_free  = !s1_valid || out_take;
    issue    = stat.ready && s1_free;
    last     = (pcc_pkg::WC_W'(row_cnt) + pcc_pkg::WC_W'(1)) == pcc_pkg::words_for(stat.total);
    for (int l = 0; l < pcc_pkg::LANES; l++) begin
      ch = pcc_pkg::DST_W'(s1_row) * pcc_pkg::DST_W'(pcc_pkg::LANES) + pcc_pkg::DST_W'(l);
      masked[l*pcc_pkg::LANE_W +: pcc_pkg::LANE_W] =
        (ch < pcc_pkg::DST_W'(s1_total)) ? bank_data[l*pcc_pkg::LANE_W +: pcc_pkg::LANE_W]
                                         : '0;
    end
  end

  assign rd.en    = issue;
  assign rd.sel   = stat.sel;
  assign rd.row   = row_cnt;
  assign buf_done = issue && last;

  assign data_out.valid      = out_valid;
  assign data_out.out_data   = out_data;
  assign data_out.pixel_last = out_pl;
  assign data_out.frame_last = out_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        row_cnt <= last ? '0 : row_cnt + pcc_pkg::ROW_W'(1);
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (data_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_row   <= row_cnt;
      s1_total <= stat.total;
      s1_fe    <= stat.frame_end;
      s1_last  <= last;
    end
    if (s1_move) begin
      out_data <= masked;
      out_pl   <= s1_last;
      out_fl   <= s1_last && s1_fe;
    end
  end

  a_read_when_ready: assert property (@(posedge clk) disable iff (rst)
    rd.en |-> stat.ready)
    else $error("row read issued with no finished pixel");

  a_frame_mark: assert property (@(posedge clk) disable iff (rst)
    (data_out.valid && data_out.frame_last) |-> data_out.pixel_last)
    else $error("frame mark without pixel mark");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (data_out.valid && !data_out.ready) |=> (data_out.valid && $stable(data_out.out_data)
      && $stable(data_out.pixel_last) && $stable(data_out.frame_last)))
    else $error("output request changed while stalled");

endmodule
